@@ design/khud_pkg.sv @@
// Shared types and constants for the keyed hash uniform draw unit.
`default_nettype none

package khud_pkg;

   // Mixing constants of the finalizer and the key whitening word.
   localparam logic [63:0] GOLDEN  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MUL_A   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MUL_B   = 64'h94d049bb133111eb;
   localparam logic [63:0] KEY_MIX = 64'h243f6a8885a308d3;

   localparam int SHIFT_A     = 30;
   localparam int SHIFT_B     = 27;
   localparam int SHIFT_OUT   = 31;
   localparam int MIX_ROUNDS  = 4;

   // The index is the upper half of the hash reduced by the span.
   localparam int DIV_WIDTH   = 32;
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = DIV_WIDTH / DIV_STEPS;

   // Coordinate selectors in mixing order.
   localparam logic [1:0] SEL_LEVEL    = 2'd0;
   localparam logic [1:0] SEL_PHASE    = 2'd1;
   localparam logic [1:0] SEL_POSITION = 2'd2;
   localparam logic [1:0] SEL_DRAW     = 2'd3;

   // One classified word as it waits in the queue.
   typedef struct packed {
      logic [31:0] level;
      logic [31:0] phase;
      logic [31:0] position;
      logic [31:0] draw;
      logic [30:0] divisor;
   } item_type;

   // One hashed word on its way into the index reduction.
   typedef struct packed {
      logic [63:0] hash;
      logic [30:0] divisor;
   } hashed_type;

endpackage

`default_nettype wire

@@ design/khud_front.sv @@
// Input stage: takes request words and classifies the span.
`default_nettype none

module khud_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [31:0]  req_comp_level,
   input  wire logic signed [31:0]  req_comp_phase,
   input  wire logic signed [31:0]  req_comp_position,
   input  wire logic signed [31:0]  req_comp_draw,
   input  wire logic [30:0]         req_span,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output khud_pkg::item_type       push_item
);
   import khud_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic     push;

   assign req_ready = !valid_ff || push_ready;
   assign accept    = req_valid && req_ready;
   assign push      = valid_ff && push_ready;

   always_comb begin
      item_in.level    = req_comp_level;
      item_in.phase    = req_comp_phase;
      item_in.position = req_comp_position;
      item_in.draw     = req_comp_draw;
      // A span of zero or one always yields index zero, which is what a divisor of one gives.
      if (req_span <= 31'd1) begin
         item_in.divisor = 31'd1;
      end else begin
         item_in.divisor = req_span;
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

`default_nettype wire

@@ design/khud_queue.sv @@
// Short first-in first-out queue between the input stage and the hash pipeline.
`default_nettype none

module khud_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire khud_pkg::item_type  in_item,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output khud_pkg::item_type       out_item
);
   import khud_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   item_type         mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != FULL);
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

@@ design/khud_mix.sv @@
// Hash pipeline: four keyed finalizer rounds, five stages each.
`default_nettype none

module khud_mix (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [63:0]          key,
   input  wire logic                 in_valid,
   input  wire khud_pkg::item_type   in_item,
   output logic                      out_valid,
   output khud_pkg::hashed_type      out_word
);
   import khud_pkg::*;

   localparam logic [31:0] A_LO = MUL_A[31:0];
   localparam logic [31:0] A_HI = MUL_A[63:32];
   localparam logic [31:0] B_LO = MUL_B[31:0];
   localparam logic [31:0] B_HI = MUL_B[63:32];

   function automatic logic [63:0] widen(input item_type it, input logic [1:0] sel);
      logic [31:0] c;
      case (sel)
         SEL_LEVEL:    c = it.level;
         SEL_PHASE:    c = it.phase;
         SEL_POSITION: c = it.position;
         SEL_DRAW:     c = it.draw;
         default:      c = it.draw;
      endcase
      return {{32{c[31]}}, c};
   endfunction

   logic          rv    [MIX_ROUNDS+1];
   logic [63:0]   racc  [MIX_ROUNDS+1];
   item_type      ritem [MIX_ROUNDS+1];

   assign rv[0]    = in_valid;
   assign racc[0]  = key;
   assign ritem[0] = in_item;

   for (genvar r = 0; r < MIX_ROUNDS; r++) begin : g_round
      logic [4:0]  v_ff;
      item_type    it_ff [5];
      logic [63:0] a_ff, a_in;
      logic [63:0] x_a, x_b;
      logic [63:0] p0_ff, p0_in, q0_ff, q0_in;
      logic [31:0] p1_ff, p1_in, p2_ff, p2_in;
      logic [31:0] q1_ff, q1_in, q2_ff, q2_in;
      logic [63:0] b_ff, b_in;
      logic [63:0] s;
      logic [63:0] h_ff, h_in;

      always_comb begin
         a_in  = racc[r] + widen(ritem[r], 2'(r)) + GOLDEN;
         // Low 64 bits of a 64 by 64 product from three 32 by 32 partial products.
         x_a   = a_ff ^ (a_ff >> SHIFT_A);
         p0_in = x_a[31:0] * A_LO;
         p1_in = x_a[31:0] * A_HI;
         p2_in = x_a[63:32] * A_LO;
         b_in  = p0_ff + {p1_ff + p2_ff, 32'h0};
         x_b   = b_ff ^ (b_ff >> SHIFT_B);
         q0_in = x_b[31:0] * B_LO;
         q1_in = x_b[31:0] * B_HI;
         q2_in = x_b[63:32] * B_LO;
         s     = q0_ff + {q1_ff + q2_ff, 32'h0};
         h_in  = s ^ (s >> SHIFT_OUT);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= '0;
         end else if (advance) begin
            v_ff <= {v_ff[3:0], rv[r]};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            it_ff[0] <= ritem[r];
            it_ff[1] <= it_ff[0];
            it_ff[2] <= it_ff[1];
            it_ff[3] <= it_ff[2];
            it_ff[4] <= it_ff[3];
            a_ff     <= a_in;
            p0_ff    <= p0_in;
            p1_ff    <= p1_in;
            p2_ff    <= p2_in;
            b_ff     <= b_in;
            q0_ff    <= q0_in;
            q1_ff    <= q1_in;
            q2_ff    <= q2_in;
            h_ff     <= h_in;
         end
      end

      assign rv[r+1]    = v_ff[4];
      assign racc[r+1]  = h_ff;
      assign ritem[r+1] = it_ff[4];
   end

   assign out_valid        = rv[MIX_ROUNDS];
   assign out_word.hash    = racc[MIX_ROUNDS];
   assign out_word.divisor = ritem[MIX_ROUNDS].divisor;

endmodule

`default_nettype wire

@@ design/khud_divider.sv @@
// Pipelined restoring remainder unit, two quotient bits per stage.
`default_nettype none

module khud_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire khud_pkg::hashed_type  in_word,
   output logic                       out_valid,
   output logic [63:0]                out_hash,
   output logic [30:0]                out_index
);
   import khud_pkg::*;

   logic                  dv    [DIV_STAGES+1];
   logic [30:0]           drem  [DIV_STAGES+1];
   logic [DIV_WIDTH-1:0]  dbits [DIV_STAGES+1];
   logic [30:0]           ddiv  [DIV_STAGES+1];
   logic [63:0]           dhash [DIV_STAGES+1];

   assign dv[0]    = in_valid;
   assign drem[0]  = '0;
   assign dbits[0] = in_word.hash[63:32];
   assign ddiv[0]  = in_word.divisor;
   assign dhash[0] = in_word.hash;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic                  v_ff;
      logic [30:0]           rem_ff, rem_in;
      logic [DIV_WIDTH-1:0]  bits_ff, bits_in;
      logic [30:0]           div_ff;
      logic [63:0]           hash_ff;
      logic [31:0]           trial;

      // The partial remainder stays below the divisor, so one subtract per bit suffices.
      always_comb begin
         rem_in  = drem[s];
         bits_in = dbits[s];
         trial   = '0;
         for (int k = 0; k < DIV_STEPS; k++) begin
            trial   = {rem_in, bits_in[DIV_WIDTH-1]};
            bits_in = {bits_in[DIV_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, ddiv[s]}) begin
               trial = trial - {1'b0, ddiv[s]};
            end
            rem_in = trial[30:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (advance) begin
            v_ff <= dv[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff  <= rem_in;
            bits_ff <= bits_in;
            div_ff  <= ddiv[s];
            hash_ff <= dhash[s];
         end
      end

      assign dv[s+1]    = v_ff;
      assign drem[s+1]  = rem_ff;
      assign dbits[s+1] = bits_ff;
      assign ddiv[s+1]  = div_ff;
      assign dhash[s+1] = hash_ff;
   end

   assign out_valid = dv[DIV_STAGES];
   assign out_hash  = dhash[DIV_STAGES];
   assign out_index = drem[DIV_STAGES];

endmodule

`default_nettype wire

@@ design/keyed_hash_uniform_draw_unit.sv @@
// Top level of the keyed hash uniform draw unit.
//
// Each request word carries four signed coordinates and a span. The unit mixes them with the
// seed through four keyed finalizer rounds and returns the 64-bit hash together with the upper
// hash half reduced modulo the span (index zero for a span of zero or one).
// Write the seed through csr_wr_en and csr_wr_data only while no word is in flight; the unit
// itself does not enforce this. The new seed takes effect on the next request.
// Both channels use valid and ready. The unit accepts one request word per cycle and returns
// one response word per cycle for as long as the receiver keeps rsp_ready high.
// A response passes from the input stage through the queue, twenty hash stages (five per round,
// two per 64-bit multiply) and sixteen remainder stages at two bits each.
// When the receiver stalls, the response is held and the hash and remainder pipelines freeze;
// the queue and input stage keep taking requests until the queue fills, then req_ready drops.
// Reset empties the pipelines and the queue and clears the seed to zero.
`default_nettype none

module keyed_hash_uniform_draw_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [63:0]         csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [31:0]  req_comp_level,
   input  wire logic signed [31:0]  req_comp_phase,
   input  wire logic signed [31:0]  req_comp_position,
   input  wire logic signed [31:0]  req_comp_draw,
   input  wire logic [30:0]         req_span,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [63:0]              rsp_hash_value,
   output logic [30:0]              rsp_draw_index
);
   import khud_pkg::*;

   // The seed is kept already whitened with the key constant.
   logic [63:0] key_ff, key_in;

   logic        push_valid, push_ready;
   item_type    push_item;
   logic        pop_valid;
   item_type    pop_item;
   logic        advance;
   logic        mix_valid;
   hashed_type  mix_word;

   assign key_in = csr_wr_data ^ KEY_MIX;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_MIX;
      end else if (csr_wr_en) begin
         key_ff <= key_in;
      end
   end

   // The back end moves whenever the response register is empty or being taken.
   assign advance = !rsp_valid || rsp_ready;

   khud_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_comp_level    (req_comp_level),
      .req_comp_phase    (req_comp_phase),
      .req_comp_position (req_comp_position),
      .req_comp_draw     (req_comp_draw),
      .req_span          (req_span),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   khud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (pop_valid),
      .out_ready (advance),
      .out_item  (pop_item)
   );

   khud_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .key       (key_ff),
      .in_valid  (pop_valid),
      .in_item   (pop_item),
      .out_valid (mix_valid),
      .out_word  (mix_word)
   );

   khud_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mix_valid),
      .in_word   (mix_word),
      .out_valid (rsp_valid),
      .out_hash  (rsp_hash_value),
      .out_index (rsp_draw_index)
   );

endmodule

`default_nettype wire

@@ tb/sv/keyed_hash_uniform_draw_checker.sv @@
`timescale 1ns / 100ps
// Checker for the keyed hash uniform draw unit: predicts every response word and compares it.
module keyed_hash_uniform_draw_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [63:0]  csr_wr_data,
   input  wire logic         req_valid,
   input  wire logic         req_ready,
   input  wire logic [31:0]  req_comp_level,
   input  wire logic [31:0]  req_comp_phase,
   input  wire logic [31:0]  req_comp_position,
   input  wire logic [31:0]  req_comp_draw,
   input  wire logic [30:0]  req_span,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_ready,
   input  wire logic [63:0]  rsp_hash_value,
   input  wire logic [30:0]  rsp_draw_index,
   output int                error_count,
   output int                pending_count
);
   import khud_pkg::*;

   typedef struct packed {
      logic [63:0] hash;
      logic [30:0] index;
   } draw_result_type;

   logic [63:0]     seed_shadow = '0;
   draw_result_type expected_draws[$];

   function automatic logic [63:0] finalize64(input logic [63:0] v);
      logic [63:0] x;
      x = v + GOLDEN;
      x = (x ^ (x >> SHIFT_A)) * MUL_A;
      x = (x ^ (x >> SHIFT_B)) * MUL_B;
      return x ^ (x >> SHIFT_OUT);
   endfunction

   function automatic logic [63:0] widen(input logic [31:0] coord);
      return {{32{coord[31]}}, coord};
   endfunction

   function automatic draw_result_type predict_draw(input logic [63:0] key,
                                                    input logic [31:0] level,
                                                    input logic [31:0] phase,
                                                    input logic [31:0] position,
                                                    input logic [31:0] draw,
                                                    input logic [30:0] span);
      draw_result_type result;
      logic [63:0]     acc;
      logic [31:0]     remainder;
      acc = key ^ KEY_MIX;
      acc = finalize64(acc + widen(level));
      acc = finalize64(acc + widen(phase));
      acc = finalize64(acc + widen(position));
      acc = finalize64(acc + widen(draw));
      // A span of zero or one always lands on index zero.
      remainder = (span > 31'd1) ? (acc[63:32] % {1'b0, span}) : 32'd0;
      result.hash = acc;
      result.index = remainder[30:0];
      return result;
   endfunction

   always @(posedge clock) begin
      draw_result_type head;
      int              faults;
      faults = 0;
      if (reset) begin
         seed_shadow <= '0;
         expected_draws.delete();
         error_count <= 0;
         pending_count <= 0;
      end else begin
         // A seed write and a request never share an edge; the old seed applies if they did.
         if (csr_wr_en) begin
            seed_shadow <= csr_wr_data;
         end
         if (req_valid && req_ready) begin
            expected_draws.insert(expected_draws.size(),
                                  predict_draw(seed_shadow, req_comp_level, req_comp_phase,
                                               req_comp_position, req_comp_draw, req_span));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_draws.size() == 0) begin
               $error("response word with no request outstanding: hash_value %h", rsp_hash_value);
               faults++;
            end else begin
               head = expected_draws.pop_front();
               if (rsp_hash_value !== head.hash) begin
                  $error("hash_value mismatch: expected %h, actual %h", head.hash, rsp_hash_value);
                  faults++;
               end
               if (rsp_draw_index !== head.index) begin
                  $error("draw_index mismatch: expected %0d, actual %0d", head.index,
                         rsp_draw_index);
                  faults++;
               end
            end
         end
         error_count <= error_count + faults;
         pending_count <= expected_draws.size();
      end
   end

endmodule

@@ tb/sv/keyed_hash_uniform_draw_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the keyed hash uniform draw unit: clock, reset, stimulus and verdict.
module keyed_hash_uniform_draw_unit_tb;
   import khud_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int IDLE_PERCENT    = 32;
   localparam int SEED_PHASES     = 6;
   localparam int WORDS_PER_PHASE = 255;
   localparam int STEADY_PHASE    = 3;
   localparam int PAUSE_PHASE     = 1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [63:0]        csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_comp_level = '0;
   logic signed [31:0] req_comp_phase = '0;
   logic signed [31:0] req_comp_position = '0;
   logic signed [31:0] req_comp_draw = '0;
   logic [30:0]        req_span = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [63:0]        rsp_hash_value;
   logic [30:0]        rsp_draw_index;

   int error_count;
   int pending_count;
   int cycle_count = 0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;

   keyed_hash_uniform_draw_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_comp_level    (req_comp_level),
      .req_comp_phase    (req_comp_phase),
      .req_comp_position (req_comp_position),
      .req_comp_draw     (req_comp_draw),
      .req_span          (req_span),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hash_value    (rsp_hash_value),
      .rsp_draw_index    (rsp_draw_index)
   );

   keyed_hash_uniform_draw_checker draw_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_comp_level    (req_comp_level),
      .req_comp_phase    (req_comp_phase),
      .req_comp_position (req_comp_position),
      .req_comp_draw     (req_comp_draw),
      .req_span          (req_span),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hash_value    (rsp_hash_value),
      .rsp_draw_index    (rsp_draw_index),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= receiver_steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic [31:0] level, input logic [31:0] phase,
                            input logic [31:0] position, input logic [31:0] draw,
                            input logic [30:0] span);
      if (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_valid <= 1'b1;
      req_comp_level <= level;
      req_comp_phase <= phase;
      req_comp_position <= position;
      req_comp_draw <= draw;
      req_span <= span;
      do @(posedge clock); while (!req_ready);
   endtask

   // The checker's count is registered, so look only after the last word has settled in.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom_range(1023);
         1: return 32'($urandom_range(8)) - 32'd4;
         2: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] random_span();
      case ($urandom_range(5))
         0: return 31'($urandom_range(1));
         1: return 31'($urandom_range(16, 2));
         2: return 31'd1 << $urandom_range(30);
         3: return 31'h7fff_ffff;
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] phase_seed(input int phase_number);
      case (phase_number)
         0: return 64'hffff_ffff_ffff_ffff;
         1: return 64'h0;
         2: return KEY_MIX;
         4: return 64'h1;
         5: return {1'b1, 31'($urandom), $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [31:0] phase_coord;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset seed of zero.
      send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'd0);
      send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'd1);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd2);
      send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
      send_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'd3);
      send_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h4000_0000);
      send_word(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 31'd7);
      send_word(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004, 31'd100);
      send_word(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 31'h2aaa_aaaa);
      send_word(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 31'h5555_5555);
      send_word(32'h0000_0005, 32'hffff_ffff, 32'h0001_0000, 32'h0000_0000, 31'h7fff_fffe);
      send_word($urandom, $urandom, $urandom, $urandom, 31'd1);
      send_word($urandom, $urandom, $urandom, $urandom, 31'd0);
      send_word($urandom, $urandom, $urandom, $urandom, 31'd2);
      send_word($urandom, $urandom, $urandom, $urandom, 31'h7fff_ffff);
      drain_results();

      for (int phase_number = 0; phase_number < SEED_PHASES; phase_number++) begin
         write_seed(phase_seed(phase_number));
         sender_steady = (phase_number == STEADY_PHASE);
         receiver_steady = (phase_number == STEADY_PHASE);
         for (int word_number = 0; word_number < WORDS_PER_PHASE; word_number++) begin
            // The initialization phase of minus one shows up often in real use.
            phase_coord = ($urandom_range(3) == 0) ? 32'hffff_ffff : random_coord();
            send_word(random_coord(), phase_coord, random_coord(), random_coord(),
                      random_span());
            if (phase_number == PAUSE_PHASE && word_number == WORDS_PER_PHASE / 2) begin
               drain_results();
            end
         end
         drain_results();
      end
      sender_steady = 1'b0;
      receiver_steady = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
